FILE: design/selp_pkg.sv
// shared types, token codes and character helpers for the sum expression lexer and parser
`timescale 1ns / 1ps

package selp_pkg;

  localparam logic [2:0] TK_ERROR  = 3'd0;
  localparam logic [2:0] TK_PLUS   = 3'd1;
  localparam logic [2:0] TK_NUMBER = 3'd2;
  localparam logic [2:0] TK_IDENT  = 3'd3;
  localparam logic [2:0] TK_WHILE  = 3'd4;
  localparam logic [2:0] TK_END    = 3'd5;

  localparam logic [1:0] V_TOKEN  = 2'd0;
  localparam logic [1:0] V_ACCEPT = 2'd1;
  localparam logic [1:0] V_ERROR  = 2'd2;

  localparam logic [2:0] KW_LEN  = 3'd5;
  localparam logic [2:0] KW_MISS = 3'd7;

  localparam logic [30:0] NUM_MAX  = 31'h7fff_ffff;
  localparam logic [15:0] LINE_MAX = 16'hffff;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } lex_mode_t;

  // one queue entry: the tokens caused by one character
  typedef struct packed {
    logic        clear;
    logic        two;
    logic [2:0]  kind0;
    logic [2:0]  kind1;
    logic [30:0] value;
    logic [15:0] line;
  } tok_entry_t;

  function automatic logic is_lower(input logic [7:0] c);
    return c inside {[8'h61:8'h7a]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  // letters of the keyword "while"
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h77;
      3'd1:    ch = 8'h68;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6c;
      3'd4:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/selp_queue.sv
// token queue between the lexer and the parser
`timescale 1ns / 1ps

module selp_queue
  import selp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tok_entry_t din,
  output logic       full,
  input  logic       pop,
  output tok_entry_t dout,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_entry_t       mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> full)
    else $error("queue count dropped without a pop");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    empty && !do_push |=> empty)
    else $error("queue filled without a push");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: design/selp_lexer.sv
// character classifier and tokenizer, one character per cycle while accept is high
`timescale 1ns / 1ps

module selp_lexer
  import selp_pkg::*;
#(
  parameter int IDENT_MAX_LEN = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       start_of_text,
  output logic       push,
  output tok_entry_t entry
);

  localparam int IW = $clog2(IDENT_MAX_LEN + 1);

  lex_mode_t     mode, mode_e, mode_next;
  logic [2:0]    kwp, kwp_e, kwp_next;
  logic [IW-1:0] ilen, ilen_e, ilen_next;
  logic [30:0]   acc, acc_e, acc_next;
  logic [15:0]   line, line_e, line_next;
  logic          pend_clear;

  logic          close_valid;
  logic [2:0]    close_kind;
  logic          idle_valid;
  logic [2:0]    idle_kind;
  logic          run_idle;
  logic [34:0]   acc_wide;
  logic [34:0]   acc_mul;
  logic [2:0]    kw_step;

  always_comb begin
    mode_e = start_of_text ? MODE_IDLE : mode;
    kwp_e  = start_of_text ? 3'd0 : kwp;
    ilen_e = start_of_text ? '0 : ilen;
    acc_e  = start_of_text ? '0 : acc;
    line_e = start_of_text ? 16'd1 : line;

    acc_wide = {4'b0, acc_e};
    acc_mul  = (acc_wide << 3) + (acc_wide << 1) + {31'b0, char_code[3:0]};
    kw_step  = ((kwp_e < KW_LEN) && (char_code == kw_char(kwp_e))) ? kwp_e + 3'd1 : KW_MISS;

    mode_next   = mode_e;
    kwp_next    = kwp_e;
    ilen_next   = ilen_e;
    acc_next    = acc_e;
    line_next   = line_e;
    close_valid = 1'b0;
    close_kind  = TK_ERROR;
    idle_valid  = 1'b0;
    idle_kind   = TK_ERROR;
    run_idle    = 1'b0;

    case (mode_e)
      MODE_IDENT: begin
        if (is_alpha(char_code)) begin
          if (ilen_e >= IW'(IDENT_MAX_LEN)) begin
            mode_next   = MODE_IDLE;
            close_valid = 1'b1;
          end else begin
            ilen_next = ilen_e + 1'b1;
            kwp_next  = kw_step;
          end
        end else begin
          mode_next   = MODE_IDLE;
          close_valid = 1'b1;
          if (!is_digit(char_code)) begin
            close_kind = (kwp_e == KW_LEN) ? TK_WHILE : TK_IDENT;
            run_idle   = 1'b1;
          end
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_code)) begin
          acc_next = (acc_mul > {4'b0, NUM_MAX}) ? NUM_MAX : acc_mul[30:0];
        end else begin
          mode_next   = MODE_IDLE;
          close_valid = 1'b1;
          if (!is_alpha(char_code)) begin
            close_kind = TK_NUMBER;
            run_idle   = 1'b1;
          end
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      if (char_code == CH_NUL) begin
        idle_valid = 1'b1;
        idle_kind  = TK_END;
      end else if (char_code == CH_SPACE || char_code == CH_CR) begin
        idle_valid = 1'b0;
      end else if (char_code == CH_LF) begin
        if (line_e < LINE_MAX) begin
          line_next = line_e + 16'd1;
        end
      end else if (is_digit(char_code)) begin
        mode_next = MODE_NUMBER;
        acc_next  = {27'b0, char_code[3:0]};
      end else if (is_lower(char_code)) begin
        mode_next = MODE_IDENT;
        ilen_next = IW'(1);
        kwp_next  = (char_code == kw_char(3'd0)) ? 3'd1 : KW_MISS;
      end else if (char_code == CH_PLUS) begin
        idle_valid = 1'b1;
        idle_kind  = TK_PLUS;
      end else begin
        idle_valid = 1'b1;
        idle_kind  = TK_ERROR;
      end
    end

    push        = accept && (close_valid || idle_valid);
    entry.clear = start_of_text || pend_clear;
    entry.two   = close_valid && idle_valid;
    entry.kind0 = close_valid ? close_kind : idle_kind;
    entry.kind1 = idle_kind;
    entry.value = (close_valid && close_kind == TK_NUMBER) ? acc_e : '0;
    entry.line  = line_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      kwp        <= 3'd0;
      ilen       <= '0;
      acc        <= '0;
      line       <= 16'd1;
      pend_clear <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      kwp        <= kwp_next;
      ilen       <= ilen_next;
      acc        <= acc_next;
      line       <= line_next;
      pend_clear <= push ? 1'b0 : (start_of_text || pend_clear);
    end
  end

`ifndef SYNTH
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line != 16'd0)
    else $error("line counter reached zero");
  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDENT |-> ilen <= IW'(IDENT_MAX_LEN) && ilen != '0)
    else $error("identifier length out of range");
  a_two_needs_close: assert property (@(posedge clk) disable iff (rst)
    push && entry.two |-> entry.kind1 != TK_NUMBER && entry.kind0 != TK_PLUS)
    else $error("bad token pair");
`endif

endmodule

FILE: design/selp_parser.sv
// grammar checker that turns queued tokens into results
`timescale 1ns / 1ps

module selp_parser
  import selp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tok_entry_t  head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [30:0] number_value,
  output logic [15:0] line_number,
  output logic [1:0]  verdict,
  output logic [2:0]  expected_kind,
  output logic        last_result
);

  logic       expect_factor, expect_factor_next;
  logic       halted, halted_next;
  logic       sub, sub_next;
  logic       ef_e, halt_e;
  logic       can_load, load;
  logic [2:0] kind;
  logic [1:0] vd;
  logic [2:0] exp_k;
  logic       halt_now;
  logic       last;

  always_comb begin
    ef_e     = (head.clear && !sub) ? 1'b1 : expect_factor;
    halt_e   = (head.clear && !sub) ? 1'b0 : halted;
    kind     = sub ? head.kind1 : head.kind0;
    can_load = !out_valid || out_ready;

    vd                 = V_TOKEN;
    exp_k              = TK_ERROR;
    halt_now           = 1'b0;
    expect_factor_next = ef_e;
    if (ef_e) begin
      if (kind == TK_NUMBER || kind == TK_IDENT) begin
        expect_factor_next = 1'b0;
      end else begin
        vd       = V_ERROR;
        exp_k    = TK_NUMBER;
        halt_now = 1'b1;
      end
    end else begin
      if (kind == TK_PLUS) begin
        expect_factor_next = 1'b1;
      end else if (kind == TK_END) begin
        vd       = V_ACCEPT;
        halt_now = 1'b1;
      end else begin
        vd       = V_ERROR;
        exp_k    = TK_END;
        halt_now = 1'b1;
      end
    end
    last = sub || !head.two || halt_now;

    load        = 1'b0;
    pop         = 1'b0;
    sub_next    = sub;
    halted_next = halted;
    if (!empty) begin
      if (halt_e) begin
        pop         = 1'b1;
        sub_next    = 1'b0;
        halted_next = 1'b1;
      end else if (can_load) begin
        load        = 1'b1;
        pop         = last;
        sub_next    = !last;
        halted_next = halt_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_factor <= 1'b1;
      halted        <= 1'b0;
      sub           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      sub    <= sub_next;
      halted <= halted_next;
      if (load) begin
        expect_factor <= expect_factor_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind    <= kind;
      number_value  <= (kind == TK_NUMBER) ? head.value : '0;
      line_number   <= head.line;
      verdict       <= vd;
      expected_kind <= exp_k;
      last_result   <= last;
    end
  end

`ifndef SYNTH
  a_expected_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((verdict == V_ERROR) == (expected_kind != TK_ERROR)))
    else $error("expected kind does not match verdict");
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != V_TOKEN |-> last_result)
    else $error("halting result not marked last");
  a_halt_follows: assert property (@(posedge clk) disable iff (rst)
    load && halt_now |=> halted)
    else $error("parser did not halt after final result");
`endif

endmodule

FILE: design/sum_expression_lexer_parser_core.sv
// top level of the streaming sum expression lexer and parser
`timescale 1ns / 1ps

// Takes one text character per transfer and reports each token with its line, value and
// the parser verdict for the grammar factor { '+' factor }. The lexer accepts one character
// every cycle while the token queue has room; the parser drains the queue at one result per
// cycle while the output is ready, so a character that closes a token and is a token itself
// (two results) leaves the queue after both. Results pass the queue memory and parser output
// registers. After an error or end of text no results come until a start_of_text transfer.

module sum_expression_lexer_parser_core
  import selp_pkg::*;
#(
  parameter int IDENT_MAX_LEN = 14,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tuser,   // start_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // number_value, line_number, verdict, expected_kind, zero pad
  output logic [2:0]  m_tuser,   // token_kind
  output logic        m_tlast    // last_result
);

  tok_entry_t  lex_entry;
  tok_entry_t  head;
  logic        lex_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        accept;
  logic [30:0] number_value;
  logic [15:0] line_number;
  logic [1:0]  verdict;
  logic [2:0]  expected_kind;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  selp_lexer #(
    .IDENT_MAX_LEN(IDENT_MAX_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (s_tdata),
    .start_of_text(s_tuser),
    .push         (lex_push),
    .entry        (lex_entry)
  );

  selp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (lex_push),
    .din  (lex_entry),
    .full (q_full),
    .pop  (q_pop),
    .dout (head),
    .empty(q_empty)
  );

  selp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .token_kind   (m_tuser),
    .number_value (number_value),
    .line_number  (line_number),
    .verdict      (verdict),
    .expected_kind(expected_kind),
    .last_result  (m_tlast)
  );

  assign m_tdata = {4'b0, expected_kind, verdict, line_number, number_value};

endmodule
